>>> hw/rtl/phx_pkg.sv
// ----------------------------------------------------------------------------
// phx_pkg: shared types and constants for the Philox4x32 block generator
// Holds the round multipliers, the key schedule increments, the register
// indexes of the configuration port and the four-word block type.
// ----------------------------------------------------------------------------
package phx_pkg;

	// Width of one counter or random word.
	localparam int unsigned WORD_W = 32;

	// Round multipliers applied to words 0 and 2.
	localparam logic [WORD_W-1:0] MUL_A = 32'hD2511F53;
	localparam logic [WORD_W-1:0] MUL_B = 32'hCD9E8D57;

	// Weyl increments that advance the two key words between rounds.
	localparam logic [WORD_W-1:0] WEYL_A = 32'h9E3779B9;
	localparam logic [WORD_W-1:0] WEYL_B = 32'hBB67AE85;

	// Configuration port.
	localparam int unsigned CFG_INDEX_W = 1;
	localparam int unsigned CFG_DATA_W  = WORD_W;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_KEY_LOW  = 1'b0,
		REG_KEY_HIGH = 1'b1
	} cfg_reg_t;

	// Four words of state that travel down the rounds.
	typedef struct packed {
		logic [WORD_W-1:0] word3;
		logic [WORD_W-1:0] word2;
		logic [WORD_W-1:0] word1;
		logic [WORD_W-1:0] word0;
	} block_t;

	// Key offset of a given round, modulo 2^32; only ever called with constants.
	function automatic logic [WORD_W-1:0] round_key_offset(
		input logic [WORD_W-1:0] weyl,
		input int unsigned       round_idx
	);
		logic [2*WORD_W-1:0] prod;
		prod = 64'(weyl) * 64'(round_idx);
		return prod[WORD_W-1:0];
	endfunction

endpackage

>>> hw/rtl/phx_if.sv
// ----------------------------------------------------------------------------
// phx_if: channel interfaces of the Philox4x32 block generator
// One interface carries counter blocks into the generator, the other carries
// random blocks out; both use a valid and ready handshake.
// ----------------------------------------------------------------------------
interface phx_ctr_if;
	logic        valid;
	logic        ready;
	logic [31:0] counter_word0;
	logic [31:0] counter_word1;
	logic [31:0] counter_word2;
	logic [31:0] counter_word3;

	modport source (
		output valid, counter_word0, counter_word1, counter_word2, counter_word3,
		input  ready
	);
	modport sink (
		input  valid, counter_word0, counter_word1, counter_word2, counter_word3,
		output ready
	);
endinterface

interface phx_rnd_if;
	logic        valid;
	logic        ready;
	logic [31:0] random_word0;
	logic [31:0] random_word1;
	logic [31:0] random_word2;
	logic [31:0] random_word3;

	modport source (
		output valid, random_word0, random_word1, random_word2, random_word3,
		input  ready
	);
	modport sink (
		input  valid, random_word0, random_word1, random_word2, random_word3,
		output ready
	);
endinterface

>>> hw/rtl/phx_round.sv
// ----------------------------------------------------------------------------
// phx_round: one Philox round as one pipeline stage
// Forms the two 32x32 products of the incoming block, mixes in the round key
// and registers the new block. A stage takes a new block whenever it is empty
// or its own block moves on in the same cycle.
// ----------------------------------------------------------------------------
module phx_round (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           up_valid,
	input  phx_pkg::block_t up_block,
	output logic           up_ready,
	input  logic [31:0]    round_key0,
	input  logic [31:0]    round_key1,
	output logic           dn_valid,
	output phx_pkg::block_t dn_block,
	input  logic           dn_ready
);

	logic            valid_s1;
	phx_pkg::block_t block_s1;
	logic [63:0]     prod_a;
	logic [63:0]     prod_b;
	phx_pkg::block_t mixed;

	// The stage accepts when empty or when its block is being taken.
	assign up_ready = !valid_s1 || dn_ready;

	// Round function: multiply, swap, and fold in the high halves and key.
	always_comb begin
		prod_a       = 64'(phx_pkg::MUL_A) * 64'(up_block.word0);
		prod_b       = 64'(phx_pkg::MUL_B) * 64'(up_block.word2);
		mixed.word0  = prod_b[63:32] ^ up_block.word1 ^ round_key0;
		mixed.word1  = prod_b[31:0];
		mixed.word2  = prod_a[63:32] ^ up_block.word3 ^ round_key1;
		mixed.word3  = prod_a[31:0];
	end

	// Stage valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (up_ready) begin
			valid_s1 <= up_valid;
		end
	end

	// Stage payload; loaded only on a transfer in.
	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			block_s1 <= mixed;
		end
	end

	assign dn_valid = valid_s1;
	assign dn_block = block_s1;

endmodule

>>> hw/rtl/philox_4x32_10_block_top.sv
// ----------------------------------------------------------------------------
// philox_4x32_10_block_top: pipelined Philox4x32 random block generator
// Turns each 128-bit counter into four random words under a 64-bit key.
//
//   channel  direction  handshake            payload
//   ctr      in         ctr.valid/ctr.ready  counter_word0..counter_word3
//   rnd      out        rnd.valid/rnd.ready  random_word0..random_word3
//   cfg      in         cfg_wr_en            cfg_index, cfg_data (key words)
//
// One round per stage, each ending in a register. Each stage holds one block
// and takes the next whenever its own moves on, so a new counter is accepted every
// cycle while the output keeps moving; the stage multipliers only set the clock period.
// Reset clears the stage valid flags and both key words to zero.
// A stalled output holds its block; stages behind it keep filling bubbles
// and hold once full, so nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module philox_4x32_10_block_top #(
	parameter int unsigned ROUND_COUNT = 10
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_wr_en,
	input  logic [phx_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [phx_pkg::CFG_DATA_W-1:0]     cfg_data,
	phx_ctr_if.sink                            ctr,
	phx_rnd_if.source                          rnd
);

	logic [31:0]     key_low_q;
	logic [31:0]     key_high_q;
	logic            stage_valid [ROUND_COUNT+1];
	logic            stage_ready [ROUND_COUNT+1];
	phx_pkg::block_t stage_block [ROUND_COUNT+1];

	// Key registers, written from the configuration port.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_low_q  <= '0;
			key_high_q <= '0;
		end else if (cfg_wr_en) begin
			unique case (phx_pkg::cfg_reg_t'(cfg_index))
				phx_pkg::REG_KEY_LOW:  key_low_q  <= cfg_data;
				phx_pkg::REG_KEY_HIGH: key_high_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Input side of the pipeline.
	assign stage_valid[0]       = ctr.valid;
	assign stage_block[0].word0 = ctr.counter_word0;
	assign stage_block[0].word1 = ctr.counter_word1;
	assign stage_block[0].word2 = ctr.counter_word2;
	assign stage_block[0].word3 = ctr.counter_word3;
	assign ctr.ready            = stage_ready[0];

	// One stage per round; each stage adds its own Weyl offset to the key.
	for (genvar r = 0; r < ROUND_COUNT; r++) begin : g_round
		logic [31:0] rk0;
		logic [31:0] rk1;

		assign rk0 = key_low_q  + phx_pkg::round_key_offset(phx_pkg::WEYL_A, r);
		assign rk1 = key_high_q + phx_pkg::round_key_offset(phx_pkg::WEYL_B, r);

		phx_round u_round (
			.clk        (clk),
			.arst_n     (arst_n),
			.up_valid   (stage_valid[r]),
			.up_block   (stage_block[r]),
			.up_ready   (stage_ready[r]),
			.round_key0 (rk0),
			.round_key1 (rk1),
			.dn_valid   (stage_valid[r+1]),
			.dn_block   (stage_block[r+1]),
			.dn_ready   (stage_ready[r+1])
		);
	end

	// The last stage register is the output register.
	assign stage_ready[ROUND_COUNT] = rnd.ready;
	assign rnd.valid                = stage_valid[ROUND_COUNT];
	assign rnd.random_word0         = stage_block[ROUND_COUNT].word0;
	assign rnd.random_word1         = stage_block[ROUND_COUNT].word1;
	assign rnd.random_word2         = stage_block[ROUND_COUNT].word2;
	assign rnd.random_word3         = stage_block[ROUND_COUNT].word3;

endmodule

>>> bench/philox_4x32_10_block_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// philox_4x32_10_block_top_tb: self-checking bench for the Philox4x32 generator
// Feeds counter blocks under a series of key settings and checks every random
// block against a bit-true model of the ten rounds. Both channels idle and
// stall in short random bursts. Key writes happen only while the pipeline is
// empty.
// ----------------------------------------------------------------------------
module philox_4x32_10_block_top_tb;

	localparam int unsigned ROUND_COUNT   = 10;
	localparam int unsigned SETTLE_CYCLES = ROUND_COUNT + 4;
	localparam int unsigned STALL_LIMIT   = 2000;
	localparam int unsigned RANDOM_PHASES = 8;
	localparam int unsigned PHASE_ITEMS   = 200;

	logic                            clk = 1'b0;
	logic                            arst_n;
	logic                            cfg_wr_en;
	logic [phx_pkg::CFG_INDEX_W-1:0] cfg_index;
	logic [phx_pkg::CFG_DATA_W-1:0]  cfg_data;

	phx_ctr_if ctr_if ();
	phx_rnd_if rnd_if ();

	philox_4x32_10_block_top #(
		.ROUND_COUNT(ROUND_COUNT)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.ctr      (ctr_if),
		.rnd      (rnd_if)
	);

	// Counters waiting to be sent, and random blocks still to come back.
	phx_pkg::block_t pending_counters[$];
	phx_pkg::block_t expected_blocks[$];

	// Model copy of the key registers.
	logic [phx_pkg::WORD_W-1:0] seed_low;
	logic [phx_pkg::WORD_W-1:0] seed_high;

	logic idle_on;
	logic ctr_fire = 1'b0;
	int   mismatch_count = 0;
	int   quiet_cycles = 0;
	int   ctr_gap = 0;
	int   rnd_stall = 0;

	// Free-running clock, 2 ns period.
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Ten Philox rounds on one counter block under the given key.
	function automatic phx_pkg::block_t philox_rounds(
		input phx_pkg::block_t            ctr,
		input logic [phx_pkg::WORD_W-1:0] k_lo,
		input logic [phx_pkg::WORD_W-1:0] k_hi
	);
		logic [2*phx_pkg::WORD_W-1:0] prod_a;
		logic [2*phx_pkg::WORD_W-1:0] prod_b;
		logic [phx_pkg::WORD_W-1:0]   k0;
		logic [phx_pkg::WORD_W-1:0]   k1;
		phx_pkg::block_t              cur;
		phx_pkg::block_t              nxt;
		cur = ctr;
		k0  = k_lo;
		k1  = k_hi;
		for (int r = 0; r < ROUND_COUNT; r++) begin
			prod_a    = 64'(phx_pkg::MUL_A) * 64'(cur.word0);
			prod_b    = 64'(phx_pkg::MUL_B) * 64'(cur.word2);
			nxt.word0 = prod_b[2*phx_pkg::WORD_W-1:phx_pkg::WORD_W] ^ cur.word1 ^ k0;
			nxt.word1 = prod_b[phx_pkg::WORD_W-1:0];
			nxt.word2 = prod_a[2*phx_pkg::WORD_W-1:phx_pkg::WORD_W] ^ cur.word3 ^ k1;
			nxt.word3 = prod_a[phx_pkg::WORD_W-1:0];
			cur       = nxt;
			k0        = k0 + phx_pkg::WEYL_A;
			k1        = k1 + phx_pkg::WEYL_B;
		end
		return cur;
	endfunction

	// A word biased towards the corners: zero, all ones, single bits and their inverses.
	function automatic logic [phx_pkg::WORD_W-1:0] pick_word();
		logic [phx_pkg::WORD_W-1:0] bit_mask;
		bit_mask = 32'h1 << $urandom_range(0, phx_pkg::WORD_W - 1);
		case ($urandom_range(0, 9))
			0:       return '0;
			1:       return '1;
			2:       return bit_mask;
			3:       return ~bit_mask;
			default: return $urandom;
		endcase
	endfunction

	// Prints one line per mismatch and counts every one.
	task automatic report_mismatch(input string what, input logic [phx_pkg::WORD_W-1:0] got,
			input logic [phx_pkg::WORD_W-1:0] want);
		$display("%0t: %s: got %h, expected %h", $realtime, what, got, want);
		mismatch_count++;
	endtask

	task automatic queue_counter(input logic [phx_pkg::WORD_W-1:0] w0,
			input logic [phx_pkg::WORD_W-1:0] w1,
			input logic [phx_pkg::WORD_W-1:0] w2, input logic [phx_pkg::WORD_W-1:0] w3);
		pending_counters.push_back({w3, w2, w1, w0});
	endtask

	// Writes one key register; the model copy follows at once, as the pipeline is empty.
	task automatic write_key(input phx_pkg::cfg_reg_t idx,
			input logic [phx_pkg::WORD_W-1:0] value);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		if (idx == phx_pkg::REG_KEY_LOW)
			seed_low = value;
		else
			seed_high = value;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// Returns at a rising edge once every counter is sent and every block has come back.
	task automatic wait_drained();
		while (pending_counters.size() != 0 || ctr_if.valid || expected_blocks.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Counter driver: holds a block until its transfer, then sends the next or idles.
	always @(negedge clk) begin : ctr_driver
		phx_pkg::block_t nxt;
		if (!arst_n) begin
			ctr_if.valid <= 1'b0;
		end else if (!ctr_if.valid || ctr_fire) begin
			if (ctr_gap == 0 && idle_on && pending_counters.size() != 0
					&& $urandom_range(0, 7) == 0)
				ctr_gap = $urandom_range(1, 3);
			if (ctr_gap != 0) begin
				ctr_gap--;
				ctr_if.valid <= 1'b0;
			end else if (pending_counters.size() != 0) begin
				nxt = pending_counters.pop_front();
				ctr_if.valid         <= 1'b1;
				ctr_if.counter_word0 <= nxt.word0;
				ctr_if.counter_word1 <= nxt.word1;
				ctr_if.counter_word2 <= nxt.word2;
				ctr_if.counter_word3 <= nxt.word3;
			end else begin
				ctr_if.valid <= 1'b0;
			end
		end
	end

	// Result receiver: ready drops in short random bursts.
	always @(negedge clk) begin
		if (!arst_n) begin
			rnd_if.ready <= 1'b0;
		end else begin
			if (rnd_stall == 0 && idle_on && $urandom_range(0, 7) == 0)
				rnd_stall = $urandom_range(1, 3);
			if (rnd_stall != 0) begin
				rnd_stall--;
				rnd_if.ready <= 1'b0;
			end else begin
				rnd_if.ready <= 1'b1;
			end
		end
	end

	// Each accepted counter yields one expected random block under the current key.
	always @(posedge clk) begin
		ctr_fire <= ctr_if.valid && ctr_if.ready;
		if (arst_n && ctr_if.valid && ctr_if.ready)
			expected_blocks.push_back(philox_rounds({ctr_if.counter_word3, ctr_if.counter_word2,
				ctr_if.counter_word1, ctr_if.counter_word0}, seed_low, seed_high));
	end

	// Checks each random block transfer against the oldest expectation.
	always @(posedge clk) begin : rnd_monitor
		phx_pkg::block_t want;
		if (arst_n && rnd_if.valid && rnd_if.ready) begin
			if (expected_blocks.size() == 0) begin
				report_mismatch("unexpected block, word0", rnd_if.random_word0, '0);
			end else begin
				want = expected_blocks.pop_front();
				if (rnd_if.random_word0 !== want.word0)
					report_mismatch("random_word0", rnd_if.random_word0, want.word0);
				if (rnd_if.random_word1 !== want.word1)
					report_mismatch("random_word1", rnd_if.random_word1, want.word1);
				if (rnd_if.random_word2 !== want.word2)
					report_mismatch("random_word2", rnd_if.random_word2, want.word2);
				if (rnd_if.random_word3 !== want.word3)
					report_mismatch("random_word3", rnd_if.random_word3, want.word3);
			end
		end
	end

	// Watchdog: ends the run when no transfer has happened for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((ctr_if.valid && ctr_if.ready) || (rnd_if.valid && rnd_if.ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
				$display("end of test: mismatches");
				$finish;
			end
		end
	end

	initial begin : stimulus
		logic [4*phx_pkg::WORD_W-1:0] stream_ctr;
		logic [phx_pkg::WORD_W-1:0]   key_val;
		phx_pkg::block_t              blk;

		// Every input known from time zero.
		arst_n               = 1'b0;
		cfg_wr_en            = 1'b0;
		cfg_index            = phx_pkg::REG_KEY_LOW;
		cfg_data             = '0;
		ctr_if.valid         = 1'b0;
		ctr_if.counter_word0 = '0;
		ctr_if.counter_word1 = '0;
		ctr_if.counter_word2 = '0;
		ctr_if.counter_word3 = '0;
		rnd_if.ready         = 1'b0;
		seed_low             = '0;
		seed_high            = '0;
		idle_on              = 1'b1;

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed part under the reset key: corner counters.
		queue_counter(32'h0, 32'h0, 32'h0, 32'h0);
		queue_counter(32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
		queue_counter(32'hAAAAAAAA, 32'h55555555, 32'hAAAAAAAA, 32'h55555555);
		queue_counter(32'h55555555, 32'hAAAAAAAA, 32'h55555555, 32'hAAAAAAAA);
		queue_counter(32'h80000000, 32'h0, 32'h80000000, 32'h0);
		queue_counter(32'h1, 32'h0, 32'h0, 32'h0);
		queue_counter(32'h0, 32'h0, 32'h1, 32'h0);
		queue_counter(32'h0, 32'h1, 32'h0, 32'h1);
		wait_drained();

		// Both key words at all ones.
		write_key(phx_pkg::REG_KEY_LOW, 32'hFFFFFFFF);
		write_key(phx_pkg::REG_KEY_HIGH, 32'hFFFFFFFF);
		queue_counter(32'h0, 32'h0, 32'h0, 32'h0);
		queue_counter(32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
		queue_counter(32'hFFFFFFFF, 32'h0, 32'hFFFFFFFF, 32'h0);
		queue_counter(32'h0, 32'hFFFFFFFF, 32'h0, 32'hFFFFFFFF);
		wait_drained();

		// The digits-of-pi key and counter, a common known-answer pair.
		write_key(phx_pkg::REG_KEY_LOW, 32'hA4093822);
		write_key(phx_pkg::REG_KEY_HIGH, 32'h299F31D0);
		queue_counter(32'h243F6A88, 32'h85A308D3, 32'h13198A2E, 32'h03707344);
		queue_counter(32'h243F6A89, 32'h85A308D3, 32'h13198A2E, 32'h03707344);
		wait_drained();

		// Random phases, each under its own key; the last two run without idling.
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			idle_on = (p < RANDOM_PHASES - 2);
			key_val = (p == 0) ? 32'h0 : (p == 1) ? 32'hFFFFFFFF : pick_word();
			write_key(phx_pkg::REG_KEY_LOW, key_val);
			key_val = (p == 0) ? 32'hFFFFFFFF : (p == 1) ? 32'h0 : pick_word();
			write_key(phx_pkg::REG_KEY_HIGH, key_val);
			stream_ctr = {pick_word(), pick_word(), pick_word(), pick_word()};
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				// Midway through one phase the sender waits for the pipeline to empty.
				if (p == 3 && i == PHASE_ITEMS / 2)
					wait_drained();
				// Half the time a consecutive counter stream, as in real use, with carries.
				case ($urandom_range(0, 3))
					0, 1: begin
						blk        = phx_pkg::block_t'(stream_ctr);
						stream_ctr = stream_ctr + 1'b1;
					end
					2:       blk = {pick_word(), pick_word(), pick_word(), pick_word()};
					default: blk = {$urandom, $urandom, $urandom, $urandom};
				endcase
				pending_counters.push_back(blk);
			end
			wait_drained();
		end

		if (mismatch_count == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

>>> files.f
hw/rtl/phx_pkg.sv
hw/rtl/phx_if.sv
hw/rtl/phx_round.sv
hw/rtl/philox_4x32_10_block_top.sv
bench/philox_4x32_10_block_top_tb.sv
